// ===== hdl/text_console_cursor_engine_unit_defines.svh =====
// Assertion macros shared by the cursor engine RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define TCCE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tcce_pkg.sv =====
// Shared constants, codes and types of the text console cursor engine.
// No dependencies; imported by the interfaces and all modules.
package tcce_pkg;

  // Fixed geometry of the tab grid and the scrollback ring.
  localparam int unsigned TAB_STOP        = 4;
  localparam int unsigned MAX_BUFFER_ROWS = 256;

  // Field widths.
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned BROWS_W    = 9;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  // Register reset values.
  localparam logic [POS_W-1:0]   COLUMNS_RST     = 8'd80;
  localparam logic [POS_W-1:0]   SCREEN_ROWS_RST = 8'd25;
  localparam logic [BROWS_W-1:0] BUFFER_ROWS_RST = 9'd250;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_VTAB      = 8'd11;
  localparam logic [CHAR_W-1:0] CHAR_FORMFEED  = 8'd12;
  localparam logic [CHAR_W-1:0] CHAR_CR        = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_LO  = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_HI  = 8'd127;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS     = 2'd0,
    CFG_SCREEN_ROWS = 2'd1,
    CFG_BUFFER_ROWS = 2'd2
  } cfg_index_t;

  // Cursor position and scroll offset.
  typedef struct packed {
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] offset;
  } tcce_cursor_t;

  // Effective geometry derived from the configuration registers.
  typedef struct packed {
    logic [POS_W-1:0] cols;
    logic [POS_W-1:0] screen;
    logic [POS_W-1:0] limit;
  } tcce_geom_t;

  // Cell write and wrap flag produced by one character.
  typedef struct packed {
    logic              write;
    logic [ADDR_W-1:0] address;
    logic [CHAR_W-1:0] char_val;
    logic              wrapped;
  } tcce_cell_t;

endpackage

// ===== hdl/tcce_if.sv =====
// Valid/ready channel interfaces for character input and cursor results.
// Depends on tcce_pkg for field widths.
interface tcce_in_if import tcce_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_of_string;

  modport source (output valid, char_code, last_of_string, input ready);
  modport sink (input valid, char_code, last_of_string, output ready);
endinterface

interface tcce_out_if import tcce_pkg::*;;
  logic              valid;
  logic              ready;
  logic              cell_write;
  logic [ADDR_W-1:0] cell_address;
  logic [CHAR_W-1:0] cell_char;
  logic [POS_W-1:0]  cursor_column;
  logic [POS_W-1:0]  cursor_row;
  logic [POS_W-1:0]  scroll_offset;
  logic              ring_wrapped;
  logic              request_done;
  logic              scroll_moved;

  modport source (output valid, cell_write, cell_address, cell_char, cursor_column,
                  cursor_row, scroll_offset, ring_wrapped, request_done, scroll_moved,
                  input ready);
  modport sink (input valid, cell_write, cell_address, cell_char, cursor_column,
                cursor_row, scroll_offset, ring_wrapped, request_done, scroll_moved,
                output ready);
endinterface

// ===== hdl/tcce_step.sv =====
// Combinational cursor update for one character: next cursor and cell write.
// Depends on tcce_pkg for types and character codes.
module tcce_step import tcce_pkg::*; (
  input  tcce_cursor_t      cur,
  input  tcce_geom_t        geom,
  input  logic [CHAR_W-1:0] char_code,
  output tcce_cursor_t      nxt,
  output tcce_cell_t        cell_res
);

  localparam logic [POS_W:0] TAB_STEP = (POS_W+1)'(TAB_STOP);

  logic               printable;
  logic [POS_W:0]     col_inc;
  logic [POS_W:0]     row_inc;
  logic [POS_W+1:0]   shift;
  logic [POS_W+1:0]   ofs_sum;
  logic [POS_W-1:0]   dn_row;
  logic [POS_W-1:0]   dn_ofs;
  logic               dn_wrap;
  logic [POS_W:0]     tab_x;
  logic [POS_W:0]     line_idx;
  logic [2*POS_W:0]   line_base;
  logic [2*POS_W:0]   addr_full;

  assign printable = (char_code >= CHAR_PRINT_LO) && (char_code <= CHAR_PRINT_HI);
  assign col_inc   = {1'b0, cur.column} + (POS_W+1)'(1);
  assign row_inc   = {1'b0, cur.row} + (POS_W+1)'(1);

  // Move down one row, scrolling the offset and wrapping the ring at the limit.
  always_comb begin
    shift   = {1'b0, row_inc} + (POS_W+2)'(1) - {2'b00, geom.screen};
    ofs_sum = {2'b00, cur.offset} + shift;
    dn_row  = row_inc[POS_W-1:0];
    dn_ofs  = cur.offset;
    dn_wrap = 1'b0;
    if (row_inc >= {1'b0, geom.screen}) begin
      if (ofs_sum >= {2'b00, geom.limit}) begin
        dn_row  = '0;
        dn_ofs  = '0;
        dn_wrap = 1'b1;
      end else begin
        dn_row = geom.screen - POS_W'(1);
        dn_ofs = ofs_sum[POS_W-1:0];
      end
    end
  end

  // Next tab stop.
  assign tab_x = {1'b0, cur.column} + TAB_STEP - ({1'b0, cur.column} % TAB_STEP);

  // Cell address: column plus columns times the buffer row, low bits kept.
  assign line_idx  = {1'b0, cur.offset} + {1'b0, cur.row};
  assign line_base = (2*POS_W+1)'(line_idx) * (2*POS_W+1)'(geom.cols);
  assign addr_full = line_base + (2*POS_W+1)'(cur.column);

  // Per-character cursor update.
  always_comb begin
    nxt          = cur;
    cell_res.write    = 1'b0;
    cell_res.address  = '0;
    cell_res.char_val = '0;
    cell_res.wrapped  = 1'b0;
    if (printable) begin
      cell_res.write    = 1'b1;
      cell_res.address  = addr_full[ADDR_W-1:0];
      cell_res.char_val = char_code;
      if (col_inc >= {1'b0, geom.cols}) begin
        nxt.column       = '0;
        nxt.row          = dn_row;
        nxt.offset       = dn_ofs;
        cell_res.wrapped = dn_wrap;
      end else begin
        nxt.column = col_inc[POS_W-1:0];
      end
    end else begin
      unique case (char_code)
        CHAR_NEWLINE, CHAR_VTAB, CHAR_FORMFEED: begin
          nxt.row          = dn_row;
          nxt.offset       = dn_ofs;
          cell_res.wrapped = dn_wrap;
        end
        CHAR_CR: begin
          nxt.column = '0;
        end
        CHAR_TAB: begin
          nxt.column = (tab_x >= {1'b0, geom.cols}) ? '0 : tab_x[POS_W-1:0];
        end
        CHAR_BACKSPACE: begin
          priority if (cur.column != '0) begin
            nxt.column = cur.column - POS_W'(1);
          end else if (cur.row != '0) begin
            nxt.column = geom.cols - POS_W'(1);
            nxt.row    = cur.row - POS_W'(1);
          end else if (cur.offset != '0) begin
            nxt.column = geom.cols - POS_W'(1);
            nxt.offset = cur.offset - POS_W'(1);
          end else begin
            nxt = cur;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

// ===== hdl/text_console_cursor_engine_unit.sv =====
// A character taken into the input stage passes to the output register once the
// register is free or its word is taken. Throughput: one character per cycle
// unless the output stalls; the cursor update is combinational.
// Reset (rst_n low, synchronous): cursor, offset and request state clear to zero,
// columns/screen_rows/buffer_rows return to 80/25/250, both stages empty.
// Top level of the text console cursor engine.
// Depends on tcce_pkg, tcce_if, tcce_step and the assertion macro header.
`include "text_console_cursor_engine_unit_defines.svh"

module text_console_cursor_engine_unit import tcce_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tcce_in_if.sink               in_ch,
  tcce_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [BROWS_W-1:0] BROWS_CAP = BROWS_W'(MAX_BUFFER_ROWS);

  // Configuration registers.
  logic [POS_W-1:0]   columns_r;
  logic [POS_W-1:0]   screen_rows_r;
  logic [BROWS_W-1:0] buffer_rows_r;

  // Input stage.
  logic               s1_valid_r;
  logic [CHAR_W-1:0]  s1_char_r;
  logic               s1_last_r;

  // Cursor and request state.
  tcce_cursor_t       cur_r;
  tcce_cursor_t       cur_nxt;
  logic [POS_W-1:0]   start_ofs_r;
  logic [POS_W-1:0]   start_ofs_nxt;
  logic               in_req_r;

  // Output register.
  logic               out_valid_r;
  tcce_cell_t         out_cell_r;
  tcce_cursor_t       out_cur_r;
  logic               out_done_r;
  logic               out_moved_r;

  tcce_geom_t         geom;
  tcce_cell_t         out_cell_nxt;
  logic [POS_W-1:0]   screen_eff;
  logic [BROWS_W-1:0] brows_eff;
  logic               advance;

  // Effective geometry: zero column and screen sizes act as one, the ring is capped.
  assign screen_eff = (screen_rows_r == '0) ? POS_W'(1) : screen_rows_r;
  assign brows_eff  = (buffer_rows_r > BROWS_CAP) ? BROWS_CAP : buffer_rows_r;
  always_comb begin
    geom.cols   = (columns_r == '0) ? POS_W'(1) : columns_r;
    geom.screen = screen_eff;
    geom.limit  = '0;
    if (brows_eff > {1'b0, screen_eff}) begin
      geom.limit = POS_W'(brows_eff - {1'b0, screen_eff});
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r     <= COLUMNS_RST;
      screen_rows_r <= SCREEN_ROWS_RST;
      buffer_rows_r <= BUFFER_ROWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COLUMNS:     columns_r     <= cfg_wdata[POS_W-1:0];
        CFG_SCREEN_ROWS: screen_rows_r <= cfg_wdata[POS_W-1:0];
        CFG_BUFFER_ROWS: buffer_rows_r <= cfg_wdata[BROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage drains whenever the output register is free or taken.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  tcce_step u_step (
    .cur       (cur_r),
    .geom      (geom),
    .char_code (s1_char_r),
    .nxt       (cur_nxt),
    .cell_res  (out_cell_nxt)
  );

  // A new request records the offset before its first character acts.
  assign start_ofs_nxt = in_req_r ? start_ofs_r : cur_r.offset;

  // Input stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_char_r <= in_ch.char_code;
      s1_last_r <= in_ch.last_of_string;
    end
  end

  // Cursor state and request tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      start_ofs_r <= '0;
      in_req_r    <= 1'b0;
    end else if (advance) begin
      cur_r       <= cur_nxt;
      start_ofs_r <= start_ofs_nxt;
      in_req_r    <= !s1_last_r;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_cell_r  <= out_cell_nxt;
      out_cur_r   <= cur_nxt;
      out_done_r  <= s1_last_r;
      out_moved_r <= s1_last_r && (cur_nxt.offset != start_ofs_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cell_write    = out_cell_r.write;
  assign out_ch.cell_address  = out_cell_r.address;
  assign out_ch.cell_char     = out_cell_r.char_val;
  assign out_ch.cursor_column = out_cur_r.column;
  assign out_ch.cursor_row    = out_cur_r.row;
  assign out_ch.scroll_offset = out_cur_r.offset;
  assign out_ch.ring_wrapped  = out_cell_r.wrapped;
  assign out_ch.request_done  = out_done_r;
  assign out_ch.scroll_moved  = out_moved_r;

  // A wrap always lands on the top row of a zero offset.
  `TCCE_ASSERT_SAME(a_wrap_home, out_valid_r && out_cell_r.wrapped,
    (out_cur_r.offset == '0) && (out_cur_r.row == '0), "wrap left cursor off home")
  // Words without a cell write carry a zero address and character.
  `TCCE_ASSERT_SAME(a_no_write_zero, out_valid_r && !out_cell_r.write,
    (out_cell_r.address == '0) && (out_cell_r.char_val == '0), "stray cell payload")
  // Scroll movement is only reported on a closing word.
  `TCCE_ASSERT_SAME(a_moved_on_done, out_valid_r && out_moved_r, out_done_r,
    "scroll_moved without request_done")
  // A closing word leaves no request open.
  `TCCE_ASSERT_NEXT(a_close_request, advance && s1_last_r, !in_req_r,
    "request still open after last character")
  // The input stage only stalls while it holds a character.
  `TCCE_ASSERT_SAME(a_stall_full, !in_ch.ready, s1_valid_r && out_valid_r,
    "input stalled without a pending word")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_console_cursor_engine_unit: a directed table, then random
// print requests under several geometries, checked against typed rows or a cursor predictor.
// Depends on tcce_pkg, the tcce_in_if/tcce_out_if interfaces and the unit's RTL.
module tb_top;
  import tcce_pkg::*;

  // One result word as the unit reports it.
  typedef struct packed {
    logic              cell_write;
    logic [ADDR_W-1:0] cell_address;
    logic [CHAR_W-1:0] cell_char;
    logic [POS_W-1:0]  column;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  offset;
    logic              ring_wrapped;
    logic              request_done;
    logic              scroll_moved;
  } cursor_word_t;

  // One row of the directed table; want is only used when typed is set.
  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              typed;
    cursor_word_t      want;
  } dir_row_t;

  // One random stretch: geometry, length, newline share and idle share in percent.
  typedef struct {
    logic [POS_W-1:0]   cols;
    logic [POS_W-1:0]   screen;
    logic [BROWS_W-1:0] brows;
    int unsigned        count;
    int unsigned        nl_pct;
    int unsigned        idle_pct;
  } geom_phase_t;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned HOLD_PHASE  = 1;
  localparam int unsigned MAX_SHOWN   = 60;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tcce_in_if  chars_if ();
  tcce_out_if cursor_if ();

  text_console_cursor_engine_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (chars_if),
    .out_ch    (cursor_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the geometry registers and the cursor state.
  logic [POS_W-1:0]   geo_cols   = COLUMNS_RST;
  logic [POS_W-1:0]   geo_screen = SCREEN_ROWS_RST;
  logic [BROWS_W-1:0] geo_brows  = BUFFER_ROWS_RST;
  logic [POS_W-1:0]   cur_col = '0;
  logic [POS_W-1:0]   cur_row = '0;
  logic [POS_W-1:0]   cur_ofs = '0;
  logic [POS_W-1:0]   req_start_ofs = '0;
  logic               req_open = 1'b0;

  cursor_word_t expected_words[$];

  int unsigned idle_pct = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned fail_count = 0;
  int unsigned shown_mismatches = 0;
  int unsigned chars_sent = 0;
  int unsigned words_checked = 0;
  int unsigned cells_written = 0;
  int unsigned ring_wraps = 0;
  int unsigned addr_overflows = 0;
  int unsigned moved_requests = 0;
  int unsigned quiet_cycles = 0;

  // Reset-value rows have their results typed in; the last rows lean on the predictor.
  dir_row_t dir_table [0:21] = '{
    '{8'd65, 1'b0, 1'b1, '{1'b1, 16'd0, 8'd65, 8'd1, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{8'd255, 1'b1, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd1, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0}},
    '{8'd127, 1'b0, 1'b1, '{1'b1, 16'd1, 8'd127, 8'd2, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{8'd32, 1'b0, 1'b1, '{1'b1, 16'd2, 8'd32, 8'd3, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{CHAR_TAB, 1'b0, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd4, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{CHAR_BACKSPACE, 1'b0, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd3, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{CHAR_CR, 1'b0, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{CHAR_BACKSPACE, 1'b0, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{CHAR_NEWLINE, 1'b0, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd0, 8'd1, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{CHAR_VTAB, 1'b0, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd0, 8'd2, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{CHAR_FORMFEED, 1'b0, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd0, 8'd3, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{CHAR_BACKSPACE, 1'b0, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd79, 8'd2, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{CHAR_TAB, 1'b0, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd0, 8'd2, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{CHAR_BACKSPACE, 1'b0, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd79, 8'd1, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{8'd88, 1'b0, 1'b1, '{1'b1, 16'd159, 8'd88, 8'd0, 8'd2, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{8'd31, 1'b0, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd0, 8'd2, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{8'd128, 1'b0, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd0, 8'd2, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{8'd0, 1'b1, 1'b1, '{1'b0, 16'd0, 8'd0, 8'd0, 8'd2, 8'd0, 1'b0, 1'b1, 1'b0}},
    '{8'd122, 1'b0, 1'b1, '{1'b1, 16'd160, 8'd122, 8'd1, 8'd2, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{CHAR_NEWLINE, 1'b0, 1'b0, '0},
    '{CHAR_FORMFEED, 1'b0, 1'b0, '0},
    '{8'd126, 1'b1, 1'b0, '0}
  };

  // The two tall-screen stretches around the one-row fold push offset plus row far enough
  // that cell addresses run past 16 bits.
  geom_phase_t geom_phases [0:8] = '{
    '{8'd1, 8'd1, 9'd2, 25, 20, 30},
    '{8'd5, 8'd3, 9'd12, 45, 25, 40},
    '{8'd7, 8'd4, 9'd3, 20, 20, 0},
    '{8'd3, 8'd1, 9'd40, 35, 25, 25},
    '{8'd255, 8'd255, 9'd256, 150, 98, 20},
    '{8'd255, 8'd1, 9'd256, 4, 100, 0},
    '{8'd255, 8'd255, 9'd256, 130, 88, 10},
    '{8'd80, 8'd25, 9'd250, 25, 15, 50},
    '{8'd13, 8'd6, 9'd200, 25, 20, 0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Move the predicted cursor down one row; returns 1 when the ring wraps to the top.
  function automatic logic scroll_down();
    int unsigned scr, br, lim, nxt, shift;
    scr = (geo_screen == 0) ? 1 : geo_screen;
    br  = (geo_brows > MAX_BUFFER_ROWS) ? MAX_BUFFER_ROWS : geo_brows;
    lim = (br > scr) ? br - scr : 0;
    nxt = cur_row + 1;
    if (nxt < scr) begin
      cur_row = nxt[POS_W-1:0];
      return 1'b0;
    end
    shift = 1 + nxt - scr;
    if (cur_ofs + shift >= lim) begin
      cur_ofs = '0;
      cur_row = '0;
      return 1'b1;
    end
    cur_row = POS_W'(scr - 1);
    cur_ofs = POS_W'(cur_ofs + shift);
    return 1'b0;
  endfunction

  // Apply one character to the predicted state and return the word it should give.
  function automatic cursor_word_t advance_cursor(input logic [CHAR_W-1:0] code,
                                                  input logic last);
    cursor_word_t w;
    int unsigned  cols, nxt, addr;
    w = '0;
    cols = (geo_cols == 0) ? 1 : geo_cols;
    if (!req_open) begin
      req_start_ofs = cur_ofs;
      req_open = 1'b1;
    end
    if (code >= CHAR_PRINT_LO && code <= CHAR_PRINT_HI) begin
      addr = cur_col + cols * (cur_ofs + cur_row);
      if (addr > 16'hFFFF) addr_overflows++;
      w.cell_write = 1'b1;
      w.cell_char = code;
      w.cell_address = addr[ADDR_W-1:0];
      nxt = cur_col + 1;
      if (nxt >= cols) begin
        cur_col = '0;
        w.ring_wrapped = scroll_down();
      end else begin
        cur_col = nxt[POS_W-1:0];
      end
    end else if (code == CHAR_NEWLINE || code == CHAR_VTAB || code == CHAR_FORMFEED) begin
      w.ring_wrapped = scroll_down();
    end else if (code == CHAR_CR) begin
      cur_col = '0;
    end else if (code == CHAR_TAB) begin
      nxt = cur_col + (TAB_STOP - (cur_col % TAB_STOP));
      cur_col = (nxt >= cols) ? '0 : nxt[POS_W-1:0];
    end else if (code == CHAR_BACKSPACE) begin
      if (cur_col != 0) begin
        cur_col = POS_W'(cur_col - 1);
      end else if (cur_row != 0) begin
        cur_row = POS_W'(cur_row - 1);
        cur_col = POS_W'(cols - 1);
      end else if (cur_ofs != 0) begin
        cur_ofs = POS_W'(cur_ofs - 1);
        cur_col = POS_W'(cols - 1);
      end
    end
    if (last) begin
      w.request_done = 1'b1;
      w.scroll_moved = (cur_ofs != req_start_ofs);
      req_open = 1'b0;
    end
    w.column = cur_col;
    w.row = cur_row;
    w.offset = cur_ofs;
    return w;
  endfunction

  // Idle length: mostly none or short, now and then a long pause.
  function automatic int unsigned idle_len();
    int unsigned r;
    if ($urandom_range(0, 99) >= idle_pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Random character with a given share of line feeds.
  function automatic logic [CHAR_W-1:0] pick_char(input int unsigned nl_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < nl_pct) begin
      case ($urandom_range(0, 2))
        0: return CHAR_NEWLINE;
        1: return CHAR_VTAB;
        default: return CHAR_FORMFEED;
      endcase
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(32, 127));
    if (r < 68) return CHAR_TAB;
    if (r < 78) return CHAR_BACKSPACE;
    if (r < 84) return CHAR_CR;
    if (r < 92) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(128, 255));
  endfunction

  // Offer one character word and record its expected result once accepted.
  // Valid stays high across back-to-back words; it drops only ahead of a gap or a drain.
  task automatic offer_char(input logic [CHAR_W-1:0] code, input logic last,
                            input logic use_fixed, input cursor_word_t fixed_word);
    int unsigned  gap;
    cursor_word_t w;
    gap = idle_len();
    if (gap != 0) begin
      chars_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.char_code <= code;
    chars_if.last_of_string <= last;
    do @(posedge clk); while (!chars_if.ready);
    w = advance_cursor(code, last);
    expected_words.push_back(use_fixed ? fixed_word : w);
    chars_sent++;
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic wait_drained();
    chars_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Write all three geometry registers on consecutive edges.
  task automatic set_geometry(input logic [POS_W-1:0] cols, input logic [POS_W-1:0] scr,
                              input logic [BROWS_W-1:0] brows);
    cfg_we <= 1'b1;
    cfg_index <= CFG_COLUMNS;
    cfg_wdata <= {1'b0, cols};
    @(posedge clk);
    cfg_index <= CFG_SCREEN_ROWS;
    cfg_wdata <= {1'b0, scr};
    @(posedge clk);
    cfg_index <= CFG_BUFFER_ROWS;
    cfg_wdata <= brows;
    @(posedge clk);
    cfg_we <= 1'b0;
    geo_cols = cols;
    geo_screen = scr;
    geo_brows = brows;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      shown_mismatches++;
      if (shown_mismatches <= MAX_SHOWN)
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Main stimulus: reset, directed table, then random print requests per geometry.
  initial begin : stimulus
    int unsigned p, left, len, k, n;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_COLUMNS;
    cfg_wdata <= '0;
    chars_if.valid <= 1'b0;
    chars_if.char_code <= '0;
    chars_if.last_of_string <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 30;
    foreach (dir_table[i])
      offer_char(dir_table[i].code, dir_table[i].last, dir_table[i].typed, dir_table[i].want);

    for (p = 0; p < $size(geom_phases); p++) begin
      wait_drained();
      set_geometry(geom_phases[p].cols, geom_phases[p].screen, geom_phases[p].brows);
      idle_pct = geom_phases[p].idle_pct;
      left = geom_phases[p].count;
      n = 0;
      while (left > 0) begin
        len = $urandom_range(1, 8);
        if (len > left) len = left;
        for (k = 0; k < len; k++) begin
          // Hold the result side off for a long stretch while words keep coming.
          if (p == HOLD_PHASE && n == 4) holds_asked++;
          offer_char(pick_char(geom_phases[p].nl_pct), k == len - 1, 1'b0, '0);
          n++;
        end
        left -= len;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_words.size() != 0) begin
      fail_count++;
      $display("%0t ns: %0d result words never arrived", $time, expected_words.size());
    end
    $display("Sent %0d characters, checked %0d result words over %0d geometries.",
             chars_sent, words_checked, $size(geom_phases) + 1);
    $display("Saw %0d cell writes, %0d ring wraps, %0d wide addresses, %0d scrolled requests.",
             cells_written, ring_wraps, addr_overflows, moved_requests);
    if (fail_count == 0)
      $display("[text_console_cursor_engine_unit] OK");
    else
      $display("[text_console_cursor_engine_unit] ERROR");
    $finish;
  end

  // Result side: random stalls, plus the long hold the stimulus asks for.
  initial begin : result_ready
    int unsigned stall;
    cursor_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        cursor_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        cursor_if.ready <= 1'b1;
      end else begin
        stall = idle_len();
        if (stall != 0) begin
          cursor_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        cursor_if.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    cursor_word_t want;
    if (rst_n && cursor_if.valid && cursor_if.ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result word, column %0d row %0d offset %0d",
                 $time, cursor_if.cursor_column, cursor_if.cursor_row,
                 cursor_if.scroll_offset);
      end else begin
        want = expected_words.pop_front();
        cells_written += want.cell_write;
        ring_wraps += want.ring_wrapped;
        moved_requests += want.scroll_moved;
        check_field("cell_write", 32'(want.cell_write), 32'(cursor_if.cell_write));
        check_field("cell_address", 32'(want.cell_address), 32'(cursor_if.cell_address));
        check_field("cell_char", 32'(want.cell_char), 32'(cursor_if.cell_char));
        check_field("cursor_column", 32'(want.column), 32'(cursor_if.cursor_column));
        check_field("cursor_row", 32'(want.row), 32'(cursor_if.cursor_row));
        check_field("scroll_offset", 32'(want.offset), 32'(cursor_if.scroll_offset));
        check_field("ring_wrapped", 32'(want.ring_wrapped), 32'(cursor_if.ring_wrapped));
        check_field("request_done", 32'(want.request_done), 32'(cursor_if.request_done));
        check_field("scroll_moved", 32'(want.scroll_moved), 32'(cursor_if.scroll_moved));
      end
    end
  end

  // Watchdog: too many cycles with no word moving on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((chars_if.valid && chars_if.ready) || (cursor_if.valid && cursor_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[text_console_cursor_engine_unit] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tcce_pkg.sv
hdl/tcce_if.sv
hdl/tcce_step.sv
hdl/text_console_cursor_engine_unit.sv
test/tb_top.sv
